FILE: design/lfvd_pkg.sv
// Shared constants and the result record for the log frame varint deframer.
package lfvd_pkg;

  // Flags byte layout.
  localparam int unsigned LevelShift = 3;
  localparam logic [7:0]  LevelMask  = 8'd7;
  localparam logic [7:0]  TsMask     = 8'd1;
  localparam int unsigned FractShift = 1;
  localparam logic [7:0]  FractMask  = 8'd3;

  // Varint decoding limits.
  localparam int unsigned VarintCountW   = 4;
  localparam logic [VarintCountW-1:0] MaxVarintBytes = 4'd10;
  localparam int unsigned VarintBits     = 7;
  localparam int unsigned ShiftW         = 7;
  localparam logic [7:0]  GroupMask      = 8'h7f;
  localparam logic [7:0]  ContinueMask   = 8'h80;

  // Result kinds.
  localparam logic KindHeader = 1'b0;
  localparam logic KindData   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [2:0]  level;
    logic        has_timestamp;
    logic [1:0]  fraction_unit;
    logic [63:0] seconds;
    logic [63:0] fraction;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic        varint_overflow;
  } result_t;

endpackage

FILE: design/lfvd_in_reg.sv
// Input register that captures one stream byte per request.
module lfvd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] stream_byte,
  output logic       byte_stall,
  output logic       q_valid,
  output logic [7:0] q_byte,
  input  logic       take_stall
);

  // The held byte leaves whenever the parser is not stalled.
  assign byte_stall = q_valid && take_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!byte_stall) begin
      q_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      q_byte <= stream_byte;
    end
  end

endmodule

FILE: design/lfvd_parser.sv
// Frame parser: phase tracking, varint accumulation and the result register.
module lfvd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  logic [7:0]       q_byte,
  output logic             stage_stall,
  output logic             result_valid,
  output lfvd_pkg::result_t result,
  input  logic             result_stall
);

  typedef enum logic [2:0] {
    PH_FLAGS    = 3'd0,
    PH_SECONDS  = 3'd1,
    PH_FRACTION = 3'd2,
    PH_LENGTH   = 3'd3,
    PH_DATA     = 3'd4
  } phase_t;

  phase_t                              phase, phase_next;
  logic [7:0]                          frame_flags, frame_flags_next;
  logic [63:0]                         acc, acc_next;
  logic [lfvd_pkg::VarintCountW-1:0]   cnt, cnt_next;
  logic [63:0]                         seconds_held, seconds_held_next;
  logic [63:0]                         fraction_held, fraction_held_next;
  logic [63:0]                         remaining, remaining_next;
  logic                                ovf, ovf_next;

  logic                                step;
  logic                                produce;
  lfvd_pkg::result_t                   res_next;

  // Varint absorb of the current byte.
  logic [6:0]                          pay;
  logic [lfvd_pkg::ShiftW-1:0]         sh;
  logic [63+7:0]                       shifted;
  logic [63:0]                         acc_abs;
  logic                                ovf_abs;
  logic [lfvd_pkg::VarintCountW-1:0]   cnt_abs;
  logic                                done;
  logic [63:0]                         rem_dec;
  logic                                ts;
  logic [1:0]                          unit;
  logic [7:0]                          level_bits;
  logic [7:0]                          unit_bits;

  assign stage_stall = result_valid && result_stall;
  assign step        = q_valid && !stage_stall;

  assign pay     = 7'(q_byte & lfvd_pkg::GroupMask);
  assign done    = (q_byte & lfvd_pkg::ContinueMask) == 8'd0;
  assign sh      = lfvd_pkg::ShiftW'(cnt) * lfvd_pkg::ShiftW'(lfvd_pkg::VarintBits);
  assign shifted = {64'd0, pay} << sh[5:0];
  assign rem_dec = remaining - 64'd1;

  assign level_bits = (frame_flags >> lfvd_pkg::LevelShift) & lfvd_pkg::LevelMask;
  assign unit_bits  = (frame_flags >> lfvd_pkg::FractShift) & lfvd_pkg::FractMask;
  assign ts         = (frame_flags & lfvd_pkg::TsMask) != 8'd0;
  assign unit       = unit_bits[1:0];

  always_comb begin
    acc_abs = acc;
    ovf_abs = ovf;
    cnt_abs = cnt;
    if (cnt < lfvd_pkg::MaxVarintBytes) begin
      if (sh < lfvd_pkg::ShiftW'(64)) begin
        acc_abs = acc | shifted[63:0];
        if (shifted[70:64] != 7'd0) begin
          ovf_abs = 1'b1;
        end
      end else if (pay != 7'd0) begin
        ovf_abs = 1'b1;
      end
      cnt_abs = cnt + lfvd_pkg::VarintCountW'(1);
    end else if (pay != 7'd0) begin
      ovf_abs = 1'b1;
    end
  end

  always_comb begin
    phase_next         = phase;
    frame_flags_next   = frame_flags;
    acc_next           = acc;
    cnt_next           = cnt;
    seconds_held_next  = seconds_held;
    fraction_held_next = fraction_held;
    remaining_next     = remaining;
    ovf_next           = ovf;
    produce            = 1'b0;
    res_next           = '0;
    if (step) begin
      case (phase)
        PH_SECONDS, PH_FRACTION, PH_LENGTH: begin
          ovf_next = ovf_abs;
          if (!done) begin
            acc_next = acc_abs;
            cnt_next = cnt_abs;
          end else begin
            acc_next = 64'd0;
            cnt_next = '0;
            case (phase)
              PH_SECONDS: begin
                seconds_held_next = acc_abs;
                phase_next = (unit != 2'd0) ? PH_FRACTION : PH_LENGTH;
              end
              PH_FRACTION: begin
                fraction_held_next = acc_abs;
                phase_next = PH_LENGTH;
              end
              default: begin
                remaining_next           = acc_abs;
                produce                  = 1'b1;
                res_next.kind            = lfvd_pkg::KindHeader;
                res_next.level           = level_bits[2:0];
                res_next.has_timestamp   = ts;
                res_next.fraction_unit   = ts ? unit : 2'd0;
                res_next.seconds         = seconds_held;
                res_next.fraction        = fraction_held;
                res_next.payload_length  = acc_abs;
                res_next.frame_end       = acc_abs == 64'd0;
                res_next.varint_overflow = ovf_abs;
                phase_next = (acc_abs != 64'd0) ? PH_DATA : PH_FLAGS;
              end
            endcase
          end
        end
        PH_DATA: begin
          remaining_next        = rem_dec;
          produce               = 1'b1;
          res_next.kind         = lfvd_pkg::KindData;
          res_next.payload_byte = q_byte;
          if (rem_dec == 64'd0) begin
            res_next.frame_end = 1'b1;
            phase_next         = PH_FLAGS;
          end
        end
        default: begin
          // Flags byte; unused phase codes land here as well.
          frame_flags_next   = q_byte;
          ovf_next           = 1'b0;
          acc_next           = 64'd0;
          cnt_next           = '0;
          seconds_held_next  = 64'd0;
          fraction_held_next = 64'd0;
          remaining_next     = 64'd0;
          phase_next = ((q_byte & lfvd_pkg::TsMask) != 8'd0) ? PH_SECONDS : PH_LENGTH;
        end
      endcase
    end
  end

  // The frame fields need no reset: the flags byte that opens each frame clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FLAGS;
      result_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (!stage_stall) begin
        result_valid <= produce;
      end
      if (produce) begin
        result <= res_next;
      end
    end
    frame_flags   <= frame_flags_next;
    acc           <= acc_next;
    cnt           <= cnt_next;
    seconds_held  <= seconds_held_next;
    fraction_held <= fraction_held_next;
    remaining     <= remaining_next;
    ovf           <= ovf_next;
  end

endmodule

FILE: design/log_frame_varint_deframer.sv
// Top level of the log frame varint deframer.
// The completing byte passes the input register, then the result register, to the ports.
// One stream byte per cycle unless a result stalls; the parser absorbs each in one pass.
// A byte is taken while a finished result still waits, as long as the result register frees.
// Reset (rst, synchronous, active high) empties both registers and expects a flags byte.
// Frame state is cleared by each flags byte, so no clearing pass is needed.
module log_frame_varint_deframer (
  input  logic        clk,
  input  logic        rst,
  // Stream byte channel.
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  stream_byte,
  // Result channel.
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [2:0]  level,
  output logic        has_timestamp,
  output logic [1:0]  fraction_unit,
  output logic [63:0] seconds,
  output logic [63:0] fraction,
  output logic [63:0] payload_length,
  output logic [7:0]  payload_byte,
  output logic        frame_end,
  output logic        varint_overflow
);

  // Byte held in the input register, on its way into the parser.
  logic              q_valid;
  logic [7:0]        q_byte;
  // High while the result register is full and its request is stalled.
  logic              stage_stall;
  lfvd_pkg::result_t result;

  // The input register decouples the stream side from the parser so a new
  // request can be taken every cycle while the parser is not stalled.
  lfvd_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .stream_byte (stream_byte),
    .byte_stall  (byte_stall),
    .q_valid     (q_valid),
    .q_byte      (q_byte),
    .take_stall  (stage_stall)
  );

  // The parser walks flags, seconds, fraction, length and data phases and
  // loads a result into its output register for header and data bytes.
  lfvd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_byte       (q_byte),
    .stage_stall  (stage_stall),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

  // Break the result record out onto its own ports.
  assign kind            = result.kind;
  assign level           = result.level;
  assign has_timestamp   = result.has_timestamp;
  assign fraction_unit   = result.fraction_unit;
  assign seconds         = result.seconds;
  assign fraction        = result.fraction;
  assign payload_length  = result.payload_length;
  assign payload_byte    = result.payload_byte;
  assign frame_end       = result.frame_end;
  assign varint_overflow = result.varint_overflow;

endmodule

FILE: design/lfvd_checker.sv
// Port-level checks for the deframer, attached to the top level by bind.
module lfvd_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic        kind,
  input logic [2:0]  level,
  input logic        has_timestamp,
  input logic [1:0]  fraction_unit,
  input logic [63:0] seconds,
  input logic [63:0] fraction,
  input logic [63:0] payload_length,
  input logic [7:0]  payload_byte,
  input logic        frame_end,
  input logic        varint_overflow
);

  // A stalled result request keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(kind) &&
      $stable(payload_byte) && $stable(payload_length) && $stable(frame_end))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  // Data results carry no header information.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && kind |-> level == 3'd0 && !has_timestamp && fraction_unit == 2'd0 &&
      seconds == 64'd0 && fraction == 64'd0 && payload_length == 64'd0 && !varint_overflow)
    else $error("data result with header fields");

  // A header ends the frame exactly when the frame has no data bytes.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !kind |-> payload_byte == 8'd0 &&
      frame_end == (payload_length == 64'd0))
    else $error("header frame end mismatch");

  // Without a timestamp the time fields stay zero.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !kind && !has_timestamp |->
      seconds == 64'd0 && fraction == 64'd0 && fraction_unit == 2'd0)
    else $error("time fields without timestamp");

endmodule

bind log_frame_varint_deframer lfvd_checker u_lfvd_checker (
  .clk             (clk),
  .rst             (rst),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .kind            (kind),
  .level           (level),
  .has_timestamp   (has_timestamp),
  .fraction_unit   (fraction_unit),
  .seconds         (seconds),
  .fraction        (fraction),
  .payload_length  (payload_length),
  .payload_byte    (payload_byte),
  .frame_end       (frame_end),
  .varint_overflow (varint_overflow)
);
